// ----- rtl/stl_pkg.sv -----
// Shared types and constants for the script token lexer.
// No dependencies; imported by every module of the block.
package stl_pkg;

    typedef enum logic [2:0] {
        MODE_SKIP    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_QUOTED  = 3'd3,
        MODE_WORD    = 3'd4
    } t_mode;

    localparam logic [1:0] KIND_WORD    = 2'd0;
    localparam logic [1:0] KIND_QUOTED  = 2'd1;
    localparam logic [1:0] KIND_SPECIAL = 2'd2;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] token_byte;
        logic       byte_valid;
        logic       token_end;
        logic [1:0] token_kind;
        logic       text_end;
    } t_result;

    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [1:0]                count;
    } t_bundle;

    function automatic t_result mk_result(logic [7:0] chr, logic valid, logic end_tok,
                                          logic [1:0] kind, logic end_text);
        t_result r;
        r.token_byte = chr;
        r.byte_valid = valid;
        r.token_end  = end_tok;
        r.token_kind = kind;
        r.text_end   = end_text;
        return r;
    endfunction

    function automatic logic is_special(logic [7:0] c);
        return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) ||
               (c == CH_RPAREN) || (c == CH_APOS) || (c == CH_COMMA);
    endfunction

endpackage

// ----- rtl/stl_decode.sv -----
// Lexer mode register and per-byte decode into up to three results.
// Depends on stl_pkg.
module stl_decode
    import stl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_text_byte,
    output t_bundle    o_bundle
);

    t_mode      r_mode;
    t_mode      n_mode;
    t_result    zero_res;
    t_result    slash_res;
    t_result    w_res0;
    t_result    w_res1;
    logic [1:0] w_cnt;
    logic       c_blank;

    assign zero_res  = mk_result(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b0);
    assign slash_res = mk_result(CH_SLASH, 1'b1, 1'b0, KIND_WORD, 1'b0);
    assign c_blank   = (i_text_byte <= CH_SPACE);

    // in-word handling shared by word and slash modes
    always_comb begin
        w_res0 = zero_res;
        w_res1 = zero_res;
        w_cnt  = 2'd1;
        if (i_text_byte == CH_NUL) begin
            w_res0 = mk_result(CH_NUL, 1'b0, 1'b1, KIND_WORD, 1'b0);
            w_res1 = mk_result(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
            w_cnt  = 2'd2;
        end else if (c_blank) begin
            w_res0 = mk_result(CH_NUL, 1'b0, 1'b1, KIND_WORD, 1'b0);
        end else if (is_special(i_text_byte)) begin
            w_res0 = mk_result(CH_NUL, 1'b0, 1'b1, KIND_WORD, 1'b0);
            w_res1 = mk_result(i_text_byte, 1'b1, 1'b1, KIND_SPECIAL, 1'b0);
            w_cnt  = 2'd2;
        end else begin
            w_res0 = mk_result(i_text_byte, 1'b1, 1'b0, KIND_WORD, 1'b0);
        end
    end

    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_SLASH, MODE_WORD: begin
                if ((r_mode == MODE_SLASH) && (i_text_byte == CH_SLASH)) begin
                    n_mode = MODE_COMMENT;
                end else if ((i_text_byte <= CH_SPACE) || is_special(i_text_byte)) begin
                    n_mode = MODE_SKIP;
                end else begin
                    n_mode = MODE_WORD;
                end
            end
            MODE_COMMENT: begin
                if ((i_text_byte == CH_NUL) || (i_text_byte == CH_NEWLINE)) begin
                    n_mode = MODE_SKIP;
                end
            end
            MODE_QUOTED: begin
                if ((i_text_byte == CH_QUOTE) || (i_text_byte == CH_NUL)) begin
                    n_mode = MODE_SKIP;
                end
            end
            default: begin
                if (c_blank || is_special(i_text_byte)) begin
                    n_mode = MODE_SKIP;
                end else if (i_text_byte == CH_SLASH) begin
                    n_mode = MODE_SLASH;
                end else if (i_text_byte == CH_QUOTE) begin
                    n_mode = MODE_QUOTED;
                end else begin
                    n_mode = MODE_WORD;
                end
            end
        endcase
    end

    always_comb begin
        o_bundle.res   = {zero_res, zero_res, zero_res};
        o_bundle.count = 2'd0;
        case (r_mode)
            MODE_SLASH: begin
                if (i_text_byte != CH_SLASH) begin
                    o_bundle.res   = {w_res1, w_res0, slash_res};
                    o_bundle.count = w_cnt + 2'd1;
                end
            end
            MODE_WORD: begin
                o_bundle.res   = {zero_res, w_res1, w_res0};
                o_bundle.count = w_cnt;
            end
            MODE_COMMENT: begin
                if (i_text_byte == CH_NUL) begin
                    o_bundle.res[0] = mk_result(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
                    o_bundle.count  = 2'd1;
                end
            end
            MODE_QUOTED: begin
                if (i_text_byte == CH_QUOTE) begin
                    o_bundle.res[0] = mk_result(CH_NUL, 1'b0, 1'b1, KIND_QUOTED, 1'b0);
                    o_bundle.count  = 2'd1;
                end else if (i_text_byte == CH_NUL) begin
                    o_bundle.res[0] = mk_result(CH_NUL, 1'b0, 1'b1, KIND_QUOTED, 1'b0);
                    o_bundle.res[1] = mk_result(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
                    o_bundle.count  = 2'd2;
                end else begin
                    o_bundle.res[0] = mk_result(i_text_byte, 1'b1, 1'b0, KIND_QUOTED, 1'b0);
                    o_bundle.count  = 2'd1;
                end
            end
            default: begin
                if (i_text_byte == CH_NUL) begin
                    o_bundle.res[0] = mk_result(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
                    o_bundle.count  = 2'd1;
                end else if (c_blank || (i_text_byte == CH_SLASH) ||
                             (i_text_byte == CH_QUOTE)) begin
                    o_bundle.count = 2'd0;
                end else if (is_special(i_text_byte)) begin
                    o_bundle.res[0] = mk_result(i_text_byte, 1'b1, 1'b1, KIND_SPECIAL, 1'b0);
                    o_bundle.count  = 2'd1;
                end else begin
                    o_bundle.res[0] = mk_result(i_text_byte, 1'b1, 1'b0, KIND_WORD, 1'b0);
                    o_bundle.count  = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SKIP;
        end else if (i_accept) begin
            r_mode <= n_mode;
        end
    end

endmodule

// ----- rtl/stl_emit.sv -----
// Result register and serializer: holds one byte's results, sends one per cycle unless stalled.
// Depends on stl_pkg.
module stl_emit
    import stl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_bundle i_bundle,
    input  logic    i_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_run_last
);

    t_bundle    r_buf;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       take;

    assign o_valid    = (r_cnt != 2'd0);
    assign take       = o_valid && !i_stall;
    assign o_ready    = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_stall);
    assign o_res      = r_buf.res[r_idx];
    assign o_run_last = (r_cnt == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load && (i_bundle.count != 2'd0)) begin
            r_cnt <= i_bundle.count;
            r_idx <= 2'd0;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_bundle;
        end
    end

endmodule

// ----- rtl/script_token_lexer.sv -----
// Top level of the script token lexer: byte decode plus result serializer.
// Depends on stl_pkg, stl_decode and stl_emit.
//
//  channel | direction | handshake           | payload
//  text    | in        | i_valid / o_stall   | i_text_byte
//  token   | out       | o_valid / i_stall   | o_token_byte, o_byte_valid, o_token_end,
//          |           |                     | o_token_kind, o_text_end, o_run_last
//
// A byte is taken in any cycle in which the result register is empty or its last result
// leaves; its results (zero to three) appear from the cycle after it is taken and leave
// one per cycle unless stalled, and a byte with results holds the input until its last leaves.
// A new byte is taken while the last result of the previous byte is being taken.
// Reset returns the lexer to skipping white space and empties the result register.
// A stall on the output holds the current result and, once it is the last, the input.
module script_token_lexer
    import stl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_token_byte,
    output logic       o_byte_valid,
    output logic       o_token_end,
    output logic [1:0] o_token_kind,
    output logic       o_text_end,
    output logic       o_run_last
);

    t_bundle bundle;
    t_result res;
    logic    ready;
    logic    accept;

    assign o_stall = !ready;
    assign accept  = i_valid && ready;

    stl_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_text_byte (i_text_byte),
        .o_bundle    (bundle)
    );

    stl_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_bundle   (bundle),
        .i_stall    (i_stall),
        .o_ready    (ready),
        .o_valid    (o_valid),
        .o_res      (res),
        .o_run_last (o_run_last)
    );

    assign o_token_byte = res.token_byte;
    assign o_byte_valid = res.byte_valid;
    assign o_token_end  = res.token_end;
    assign o_token_kind = res.token_kind;
    assign o_text_end   = res.text_end;

endmodule

// ----- tb/tb_script_token_lexer.sv -----
// Testbench for script_token_lexer: drives text bytes, predicts the token results
// and checks each one field by field. Depends on stl_pkg and the lexer RTL.
`timescale 1ns / 1ps

module tb_script_token_lexer;
    import stl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] chr;
        logic       valid;
        logic       tok_end;
        logic [1:0] kind;
        logic       txt_end;
        logic       last;
    } t_token_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_text_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_token_byte;
    logic       o_byte_valid;
    logic       o_token_end;
    logic [1:0] o_token_kind;
    logic       o_text_end;
    logic       o_run_last;

    logic [7:0]  text_pending[$];
    t_token_beat beats_due[$];
    t_mode       lex_mode = MODE_SKIP;
    logic [7:0]  punct_chars[6];

    int   mismatches = 0;
    int   cycles = 0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    logic hold_req = 1'b0;
    logic quiet = 1'b0;
    logic text_taken = 1'b0;

    script_token_lexer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_text_byte  (i_text_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_token_byte (o_token_byte),
        .o_byte_valid (o_byte_valid),
        .o_token_end  (o_token_end),
        .o_token_kind (o_token_kind),
        .o_text_end   (o_text_end),
        .o_run_last   (o_run_last)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic is_punct(logic [7:0] c);
        return c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN ||
               c == CH_RPAREN || c == CH_APOS || c == CH_COMMA;
    endfunction

    function automatic void emit_beat(logic [7:0] chr, logic v, logic e, logic [1:0] k,
                                      logic t);
        t_token_beat b;
        b.chr     = chr;
        b.valid   = v;
        b.tok_end = e;
        b.kind    = k;
        b.txt_end = t;
        b.last    = 1'b0;
        beats_due.push_back(b);
    endfunction

    function automatic void word_byte(logic [7:0] c);
        if (c == CH_NUL) begin
            emit_beat(CH_NUL, 1'b0, 1'b1, KIND_WORD, 1'b0);
            emit_beat(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
            lex_mode = MODE_SKIP;
        end else if (c <= CH_SPACE) begin
            emit_beat(CH_NUL, 1'b0, 1'b1, KIND_WORD, 1'b0);
            lex_mode = MODE_SKIP;
        end else if (is_punct(c)) begin
            emit_beat(CH_NUL, 1'b0, 1'b1, KIND_WORD, 1'b0);
            emit_beat(c, 1'b1, 1'b1, KIND_SPECIAL, 1'b0);
            lex_mode = MODE_SKIP;
        end else begin
            emit_beat(c, 1'b1, 1'b0, KIND_WORD, 1'b0);
            lex_mode = MODE_WORD;
        end
    endfunction

    function automatic void start_byte(logic [7:0] c);
        if (c == CH_NUL) begin
            emit_beat(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
            lex_mode = MODE_SKIP;
        end else if (c <= CH_SPACE) begin
            lex_mode = MODE_SKIP;
        end else if (c == CH_SLASH) begin
            lex_mode = MODE_SLASH;
        end else if (c == CH_QUOTE) begin
            lex_mode = MODE_QUOTED;
        end else if (is_punct(c)) begin
            emit_beat(c, 1'b1, 1'b1, KIND_SPECIAL, 1'b0);
            lex_mode = MODE_SKIP;
        end else begin
            emit_beat(c, 1'b1, 1'b0, KIND_WORD, 1'b0);
            lex_mode = MODE_WORD;
        end
    endfunction

    function automatic void lex_byte(logic [7:0] c);
        int          first;
        t_token_beat b;
        first = beats_due.size();
        case (lex_mode)
            MODE_SLASH: begin
                if (c == CH_SLASH) begin
                    lex_mode = MODE_COMMENT;
                end else begin
                    emit_beat(CH_SLASH, 1'b1, 1'b0, KIND_WORD, 1'b0);
                    word_byte(c);
                end
            end
            MODE_COMMENT: begin
                if (c == CH_NUL) begin
                    emit_beat(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
                    lex_mode = MODE_SKIP;
                end else if (c == CH_NEWLINE) begin
                    lex_mode = MODE_SKIP;
                end
            end
            MODE_QUOTED: begin
                if (c == CH_QUOTE) begin
                    emit_beat(CH_NUL, 1'b0, 1'b1, KIND_QUOTED, 1'b0);
                    lex_mode = MODE_SKIP;
                end else if (c == CH_NUL) begin
                    emit_beat(CH_NUL, 1'b0, 1'b1, KIND_QUOTED, 1'b0);
                    emit_beat(CH_NUL, 1'b0, 1'b0, KIND_WORD, 1'b1);
                    lex_mode = MODE_SKIP;
                end else begin
                    emit_beat(c, 1'b1, 1'b0, KIND_QUOTED, 1'b0);
                end
            end
            MODE_WORD: word_byte(c);
            default:   start_byte(c);
        endcase
        if (beats_due.size() > first) begin
            b = beats_due.pop_back();
            b.last = 1'b1;
            beats_due.push_back(b);
        end
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_script_token_lexer failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : watch_tokens
        t_token_beat want;
        text_taken = i_rst_n && i_valid && !o_stall;
        if (text_taken)
            lex_byte(i_text_byte);
        if (i_rst_n && o_valid && !i_stall) begin
            if (beats_due.size() == 0) begin
                report_mismatch("token result with none expected");
            end else begin
                want = beats_due.pop_front();
                if (o_token_byte !== want.chr)
                    report_mismatch($sformatf("token_byte %h, want %h", o_token_byte, want.chr));
                if (o_byte_valid !== want.valid)
                    report_mismatch($sformatf("byte_valid %b, want %b", o_byte_valid, want.valid));
                if (o_token_end !== want.tok_end)
                    report_mismatch($sformatf("token_end %b, want %b", o_token_end, want.tok_end));
                if (o_token_kind !== want.kind)
                    report_mismatch($sformatf("token_kind %0d, want %0d", o_token_kind, want.kind));
                if (o_text_end !== want.txt_end)
                    report_mismatch($sformatf("text_end %b, want %b", o_text_end, want.txt_end));
                if (o_run_last !== want.last)
                    report_mismatch($sformatf("run_last %b, want %b", o_run_last, want.last));
            end
        end
    end

    always @(negedge i_clk) begin : drive_text
        logic       v;
        logic [7:0] b;
        v = i_valid;
        b = i_text_byte;
        if (!i_rst_n) begin
            v = 1'b0;
        end else if (!i_valid || text_taken) begin
            v = 1'b0;
            if (send_gap == 0 && !quiet && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 4);
            if (send_gap > 0) begin
                send_gap--;
            end else if (text_pending.size() > 0) begin
                v = 1'b1;
                b = text_pending.pop_front();
            end
        end
        i_valid <= v;
        i_text_byte <= b;
    end

    always @(negedge i_clk) begin : drive_stall
        logic s;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            s = 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            s = 1'b1;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            s = 1'b1;
            stall_left = $urandom_range(0, 3);
        end else begin
            s = 1'b0;
        end
        i_stall <= s;
    end

    function automatic logic [7:0] rand_byte(int lo, int hi);
        return 8'($urandom_range(lo, hi));
    endfunction

    task automatic queue_token(inout int produced);
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                n = $urandom_range(1, 6);
                repeat (n) text_pending.push_back(rand_byte(33, 255));
                produced += n;
            end
            3: begin
                n = $urandom_range(0, 5);
                text_pending.push_back(CH_QUOTE);
                repeat (n) text_pending.push_back(rand_byte(1, 255));
                text_pending.push_back(($urandom_range(0, 7) != 0) ? CH_QUOTE : CH_NUL);
                produced += n + 2;
            end
            4: begin
                text_pending.push_back(punct_chars[$urandom_range(0, 5)]);
                produced += 1;
            end
            5: begin
                n = $urandom_range(0, 5);
                text_pending.push_back(CH_SLASH);
                text_pending.push_back(CH_SLASH);
                repeat (n) text_pending.push_back(rand_byte(1, 255));
                text_pending.push_back(($urandom_range(0, 7) != 0) ? CH_NEWLINE : CH_NUL);
            end
            6: text_pending.push_back(rand_byte(1, 32));
            7: begin
                text_pending.push_back(CH_SLASH);
                text_pending.push_back(rand_byte(0, 255));
                produced += 2;
            end
            8: begin
                text_pending.push_back(CH_NUL);
                produced += 1;
            end
            default: begin
                text_pending.push_back(rand_byte(0, 255));
                produced += 1;
            end
        endcase
    endtask

    task automatic wait_drained();
        while (text_pending.size() > 0 || i_valid || beats_due.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int produced;
        punct_chars = '{CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_APOS, CH_COMMA};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_text_byte = CH_NUL;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // word with slashes and a quote, ended by a special, then quoted text, comments, specials and NULs
        text_pending = '{CH_SPACE, 8'hFF, CH_SLASH, CH_SLASH, CH_QUOTE, CH_COMMA,
                         CH_QUOTE, CH_QUOTE, CH_SLASH, 8'h78, CH_SPACE,
                         CH_SLASH, CH_SLASH, 8'hFF, CH_NUL,
                         CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_APOS,
                         CH_QUOTE, 8'h01, CH_NUL, CH_SLASH, CH_LBRACE,
                         CH_SLASH, CH_NUL, CH_NUL, 8'h7F, CH_NEWLINE};
        wait_drained();

        // hold the output so the block backs up
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++)
            text_pending.push_back((k % 5 == 4) ? CH_SPACE : rand_byte(8'h61, 8'h7A));
        wait_drained();

        produced = 0;
        while (produced < 80)
            queue_token(produced);
        while (text_pending.size() > 0)
            @(posedge i_clk);
        quiet = 1'b1;
        produced = 0;
        while (produced < 20)
            queue_token(produced);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && beats_due.size() == 0) begin
            $display("tb_script_token_lexer passed");
        end else begin
            $display("tb_script_token_lexer failed");
        end
        $finish;
    end

endmodule
